// File: sv/fbs_pkg.sv
package fbs_pkg;

    localparam int MAX_BLOCK_SIZE_DEF = 32;

    // register map, index = paddr[2]
    localparam logic REG_TENSOR_SCALE = 1'b0;
    localparam logic REG_BLOCK_SIZE   = 1'b1;

    localparam logic [31:0] TENSOR_SCALE_RST = 32'h3F80_0000;
    localparam logic [5:0]  BLOCK_SIZE_RST   = 6'd16;

    localparam logic [31:0] GLOBAL_MULT = 32'h7B80_0000;  // 2^120
    localparam logic [31:0] ELEM_MULT   = 32'h7E80_0000;  // 2^126
    localparam logic [31:0] FP32_QNAN   = 32'h7FC0_0000;
    localparam logic [15:0] BF16_QNAN   = 16'h7FC0;

    // E4M3 code widened by bit placement
    function automatic logic [31:0] place_e4m3(input logic [7:0] c);
        place_e4m3 = {c[7], 4'b0000, c[6:0], 20'd0};
    endfunction

    // E2M1 code widened by bit placement
    function automatic logic [31:0] place_e2m1(input logic [3:0] c);
        place_e2m1 = {c[3], 6'd0, c[2:0], 22'd0};
    endfunction

    // fp32 to bf16, ties away from zero, NaN made canonical
    function automatic logic [15:0] to_bf16(input logic [31:0] b);
        logic [31:0] sum;
        sum = b + 32'h0000_8000;
        if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
            to_bf16 = BF16_QNAN;
        end else begin
            to_bf16 = sum[31:16];
        end
    endfunction

endpackage

// File: sv/fbs_ram.sv
module fbs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/fbs_fpmul.sv
// fp32 multiplier, RNE, subnormals; normalization one bit per cycle
module fbs_fpmul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic        done,
    output logic [31:0] result
);
    import fbs_pkg::*;

    typedef enum logic [2:0] {M_IDLE, M_MUL, M_NORM, M_DEN, M_RND} mstate_t;

    mstate_t            state_reg;
    logic               sign_reg;
    logic [23:0]        ma_reg, mb_reg;
    logic signed [10:0] exp_reg;
    logic [47:0]        prod_reg;
    logic               sticky_reg;
    logic [31:0]        result_reg;
    logic               done_reg;

    logic [7:0]  ea, eb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic        guard, st, up;
    logic [24:0] m25;
    logic signed [10:0] ex;
    logic [22:0] frac;

    always_comb begin
        ea     = op_a[30:23];
        eb     = op_b[30:23];
        a_nan  = (ea == 8'hFF) && (op_a[22:0] != 23'd0);
        b_nan  = (eb == 8'hFF) && (op_b[22:0] != 23'd0);
        a_inf  = (ea == 8'hFF) && (op_a[22:0] == 23'd0);
        b_inf  = (eb == 8'hFF) && (op_b[22:0] == 23'd0);
        a_zero = (ea == 8'h00) && (op_a[22:0] == 23'd0);
        b_zero = (eb == 8'h00) && (op_b[22:0] == 23'd0);
        sgn    = op_a[31] ^ op_b[31];

        guard = prod_reg[23];
        st    = (|prod_reg[22:0]) | sticky_reg;
        up    = guard & (st | prod_reg[24]);
        m25   = {1'b0, prod_reg[47:24]} + {24'd0, up};
        if (m25[24]) begin
            ex   = exp_reg + 11'sd1;
            frac = 23'd0;
        end else if (m25[23]) begin
            ex   = exp_reg;
            frac = m25[22:0];
        end else begin
            ex   = 11'sd0;
            frac = m25[22:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        sign_reg <= sgn;
                        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
                            result_reg <= FP32_QNAN;
                            done_reg   <= 1'b1;
                        end else if (a_inf || b_inf) begin
                            result_reg <= {sgn, 8'hFF, 23'd0};
                            done_reg   <= 1'b1;
                        end else if (a_zero || b_zero) begin
                            result_reg <= {sgn, 31'd0};
                            done_reg   <= 1'b1;
                        end else begin
                            ma_reg    <= {ea != 8'h00, op_a[22:0]};
                            mb_reg    <= {eb != 8'h00, op_b[22:0]};
                            // biased exponent with the leading one at bit 47
                            exp_reg   <= $signed({3'b000, (ea == 8'h00) ? 8'd1 : ea})
                                       + $signed({3'b000, (eb == 8'h00) ? 8'd1 : eb})
                                       - 11'sd126;
                            state_reg <= M_MUL;
                        end
                    end
                end
                M_MUL: begin
                    prod_reg   <= ma_reg * mb_reg;
                    sticky_reg <= 1'b0;
                    state_reg  <= M_NORM;
                end
                M_NORM: begin
                    if (prod_reg == 48'd0) begin
                        result_reg <= {sign_reg, 31'd0};
                        done_reg   <= 1'b1;
                        state_reg  <= M_IDLE;
                    end else if (!prod_reg[47] && exp_reg > 11'sd1) begin
                        prod_reg <= {prod_reg[46:0], 1'b0};
                        exp_reg  <= exp_reg - 11'sd1;
                    end else if (exp_reg < 11'sd1) begin
                        state_reg <= M_DEN;
                    end else begin
                        state_reg <= M_RND;
                    end
                end
                M_DEN: begin
                    if (exp_reg < -11'sd60) begin
                        // everything falls into sticky
                        prod_reg   <= 48'd0;
                        sticky_reg <= 1'b1;
                        exp_reg    <= 11'sd1;
                        state_reg  <= M_RND;
                    end else if (exp_reg < 11'sd1) begin
                        sticky_reg <= sticky_reg | prod_reg[0];
                        prod_reg   <= {1'b0, prod_reg[47:1]};
                        exp_reg    <= exp_reg + 11'sd1;
                    end else begin
                        state_reg <= M_RND;
                    end
                end
                M_RND: begin
                    if (ex >= 11'sd255) begin
                        result_reg <= {sign_reg, 8'hFF, 23'd0};
                    end else begin
                        result_reg <= {sign_reg, ex[7:0], frac};
                    end
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule

// File: sv/fp4_block_scaled_to_bf16_unit.sv
// channel  | ports                                       | accepted when
// ---------+---------------------------------------------+----------------------
// input    | s_packed_pair, s_high/low_half_scale        | s_valid && s_ready
// result   | m_value_bf16, m_last_of_run                 | m_valid && m_ready
// config   | psel/penable/pwrite/paddr/pwdata, prdata    | psel && penable && pwrite
//
// One beat at a time. Each element is two passes through one shared fp32
// multiplier (a pass skips normalization for a zero, infinite or NaN operand,
// else its normalizer shifts one bit per cycle); a block's first beat adds
// three passes for the scale factors.
// A block's last beat then replays every kept low nibble from the code RAM.
// aresetn is synchronous, active low; the code RAM is not cleared.
// A stalled result holds the sequencer until the output register frees.
module fp4_block_scaled_to_bf16_unit #(
    parameter int MAX_BLOCK_SIZE = fbs_pkg::MAX_BLOCK_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_packed_pair,
    input  logic [7:0]  s_high_half_scale,
    input  logic [7:0]  s_low_half_scale,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_value_bf16,
    output logic        m_last_of_run
);
    import fbs_pkg::*;

    localparam int PW = $clog2(MAX_BLOCK_SIZE);

    typedef enum logic [3:0] {
        S_IDLE, S_GLOB, S_HF, S_LF, S_E1, S_E2, S_EMIT, S_FETCH, S_LOADC
    } state_t;

    state_t         state_reg;
    logic [31:0]    tensor_scale_reg;
    logic [5:0]     block_size_reg;
    logic [PW-1:0]  pos_reg, idx_reg;
    logic           end_reg, is_low_reg, issued_reg;
    logic [3:0]     code_reg;
    logic [7:0]     hs_reg, ls_reg;
    logic [31:0]    glob_reg, hf_reg, lf_reg, tmp_reg;
    logic           m_valid_reg, m_last_reg;
    logic [15:0]    m_value_reg;

    logic           cfg_wr, accept, mul_start, mul_done, is_mul_state;
    logic [31:0]    mul_a, mul_b, mul_res;
    logic [6:0]     eff, pos_inc;
    logic [3:0]     ram_rdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == REG_BLOCK_SIZE) ? {26'd0, block_size_reg} : tensor_scale_reg;
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    // effective block size: 0 acts as 1, clipped at the RAM depth
    always_comb begin
        if (block_size_reg == 6'd0) begin
            eff = 7'd1;
        end else if ({1'b0, block_size_reg} > 7'(MAX_BLOCK_SIZE)) begin
            eff = 7'(MAX_BLOCK_SIZE);
        end else begin
            eff = {1'b0, block_size_reg};
        end
        pos_inc = 7'(pos_reg) + 7'd1;
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a        = 32'd0;
        mul_b        = 32'd0;
        is_mul_state = 1'b1;
        case (state_reg)
            S_GLOB: begin
                mul_a = tensor_scale_reg;
                mul_b = GLOBAL_MULT;
            end
            S_HF: begin
                mul_a = place_e4m3(hs_reg);
                mul_b = glob_reg;
            end
            S_LF: begin
                mul_a = place_e4m3(ls_reg);
                mul_b = glob_reg;
            end
            S_E1: begin
                mul_a = place_e2m1(code_reg);
                mul_b = ELEM_MULT;
            end
            S_E2: begin
                mul_a = tmp_reg;
                mul_b = is_low_reg ? lf_reg : hf_reg;
            end
            default: is_mul_state = 1'b0;
        endcase
        mul_start = is_mul_state && !issued_reg;
    end

    fbs_fpmul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    // low nibbles of the current block, in byte order
    fbs_ram #(.WIDTH(4), .DEPTH(MAX_BLOCK_SIZE)) u_codes (
        .aclk  (aclk),
        .we    (accept),
        .waddr (pos_reg),
        .wdata (s_packed_pair[3:0]),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            tensor_scale_reg <= TENSOR_SCALE_RST;
            block_size_reg   <= BLOCK_SIZE_RST;
            pos_reg          <= '0;
            idx_reg          <= '0;
            issued_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
            glob_reg         <= 32'd0;
            hf_reg           <= 32'd0;
            lf_reg           <= 32'd0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_TENSOR_SCALE) begin
                    tensor_scale_reg <= pwdata;
                end else begin
                    block_size_reg <= pwdata[5:0];
                end
            end

            // S_EMIT reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end

            if (mul_start) begin
                issued_reg <= 1'b1;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        code_reg   <= s_packed_pair[7:4];
                        hs_reg     <= s_high_half_scale;
                        ls_reg     <= s_low_half_scale;
                        end_reg    <= (pos_inc >= eff);
                        is_low_reg <= 1'b0;
                        state_reg  <= (pos_reg == '0) ? S_GLOB : S_E1;
                    end
                end
                S_GLOB: begin
                    if (mul_done) begin
                        glob_reg   <= mul_res;
                        issued_reg <= 1'b0;
                        state_reg  <= S_HF;
                    end
                end
                S_HF: begin
                    if (mul_done) begin
                        hf_reg     <= mul_res;
                        issued_reg <= 1'b0;
                        state_reg  <= S_LF;
                    end
                end
                S_LF: begin
                    if (mul_done) begin
                        lf_reg     <= mul_res;
                        issued_reg <= 1'b0;
                        state_reg  <= S_E1;
                    end
                end
                S_E1: begin
                    if (mul_done) begin
                        tmp_reg    <= mul_res;
                        issued_reg <= 1'b0;
                        state_reg  <= S_E2;
                    end
                end
                S_E2: begin
                    if (mul_done) begin
                        tmp_reg    <= mul_res;
                        issued_reg <= 1'b0;
                        state_reg  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= to_bf16(tmp_reg);
                        if (is_low_reg) begin
                            m_last_reg <= (idx_reg == pos_reg);
                            if (idx_reg == pos_reg) begin
                                pos_reg   <= '0;
                                state_reg <= S_IDLE;
                            end else begin
                                idx_reg   <= idx_reg + 1'b1;
                                state_reg <= S_FETCH;
                            end
                        end else begin
                            m_last_reg <= !end_reg;
                            if (end_reg) begin
                                idx_reg   <= '0;
                                state_reg <= S_FETCH;
                            end else begin
                                pos_reg   <= pos_reg + 1'b1;
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                end
                S_FETCH: state_reg <= S_LOADC;   // RAM read in flight
                S_LOADC: begin
                    code_reg   <= ram_rdata;
                    is_low_reg <= 1'b1;
                    state_reg  <= S_E1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_value_bf16  = m_value_reg;
    assign m_last_of_run = m_last_reg;

    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("new beat taken while one is in work");

    a_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == S_GLOB || state_reg == S_HF || state_reg == S_LF ||
                      state_reg == S_E1 || state_reg == S_E2))
        else $error("multiplier result arrived outside a multiply step");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !issued_reg)
        else $error("multiply still outstanding in idle");

    a_flush_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOADC) |-> (idx_reg <= pos_reg))
        else $error("flush index ran past the block");
endmodule
